>>> design/opq_pkg.sv
// shared types and constants for the order price priority queue
`timescale 1ns / 1ps

package opq_pkg;

    localparam int PRICE_W   = 20;
    localparam int SHARES_W  = 24;
    localparam int USER_W    = 16;
    localparam int COUNT_W   = 5;
    localparam int DEF_DEPTH = 16;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef struct packed {
        logic [PRICE_W-1:0]  price;
        logic [SHARES_W-1:0] shares;
        logic [USER_W-1:0]   user;
    } t_entry;

endpackage

>>> design/order_price_priority_queue_core.sv
// sorted order store with one shared price comparator and a shifting sequencer
// push walks S_PRD/S_PCMP, pop S_QRD/S_QCMP; refused words go straight to S_FIN, S_BEST
// next word is taken the cycle after a result loads
// each stored slot takes a registered read then a compare or write
// reset clears count, direction and handshake state; slot memory is not cleared
`timescale 1ns / 1ps

module order_price_priority_queue_core #(
    parameter int DEPTH = opq_pkg::DEF_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_kind,
    input  logic [opq_pkg::PRICE_W-1:0]  i_entry_price,
    input  logic [opq_pkg::SHARES_W-1:0] i_entry_shares,
    input  logic [opq_pkg::USER_W-1:0]   i_entry_user,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_op_done,
    output logic [opq_pkg::PRICE_W-1:0]  o_best_price,
    output logic [opq_pkg::SHARES_W-1:0] o_best_shares,
    output logic [opq_pkg::USER_W-1:0]   o_best_user,
    output logic [opq_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                         o_is_empty,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data
);
    import opq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRD  = 3'd1;
    localparam logic [2:0] S_PCMP = 3'd2;
    localparam logic [2:0] S_QRD  = 3'd3;
    localparam logic [2:0] S_QCMP = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_BEST = 3'd6;

    t_entry mem [DEPTH];

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_done, n_done;
    logic          r_carry, n_carry;
    logic          r_desc;
    t_entry        r_new;
    t_entry        r_rd_data;
    logic          r_out_valid, n_out_valid;
    logic          r_out_done;
    t_entry        r_out_best;
    logic [CW-1:0] r_out_count;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_wdata;
    logic [AW-1:0] w_raddr;
    logic          w_beats;
    logic          w_accept;
    logic          w_load_out;
    logic          w_swap;

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_beats  = r_desc ? (r_new.price > r_rd_data.price)
                             : (r_new.price < r_rd_data.price);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_done      = r_done;
        n_carry     = r_carry;
        n_out_valid = r_out_valid && i_stall;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = r_new;
        w_raddr     = r_idx;
        w_load_out  = 1'b0;
        w_swap      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_carry = 1'b0;
                    if (i_kind == KIND_PUSH) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_done  = 1'b0;
                            n_state = S_FIN;
                        end else begin
                            n_done  = 1'b1;
                            n_idx   = '0;
                            n_count = r_count + 1'b1;
                            n_state = S_PRD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_done  = 1'b0;
                            n_state = S_FIN;
                        end else begin
                            n_done  = 1'b1;
                            n_idx   = '0;
                            n_state = S_QRD;
                        end
                    end
                end
            end
            S_PRD: begin
                if (CW'(r_idx) + 1'b1 == r_count) begin
                    w_we    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    w_raddr = r_idx;
                    n_state = S_PCMP;
                end
            end
            S_PCMP: begin
                // once placed, every later slot moves back by one
                if (r_carry || w_beats) begin
                    w_we    = 1'b1;
                    w_swap  = 1'b1;
                    n_carry = 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_PRD;
            end
            S_QRD: begin
                if (CW'(r_idx) + 1'b1 == r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_FIN;
                end else begin
                    w_raddr = r_idx + 1'b1;
                    n_state = S_QCMP;
                end
            end
            S_QCMP: begin
                w_we    = 1'b1;
                w_wdata = r_rd_data;
                n_idx   = r_idx + 1'b1;
                n_state = S_QRD;
            end
            S_FIN: begin
                w_raddr = '0;
                n_state = S_BEST;
            end
            S_BEST: begin
                w_raddr = '0;
                if (!r_out_valid || !i_stall) begin
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_done      <= 1'b0;
            r_carry     <= 1'b0;
            r_desc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_done      <= n_done;
            r_carry     <= n_carry;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_desc <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_new.price  <= i_entry_price;
            r_new.shares <= i_entry_shares;
            r_new.user   <= i_entry_user;
        end else if (w_swap) begin
            r_new <= r_rd_data;
        end
        if (w_load_out) begin
            r_out_done  <= r_done;
            r_out_count <= r_count;
            r_out_best  <= (r_count == '0) ? '0 : r_rd_data;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_op_done     = r_out_done;
    assign o_best_price  = r_out_best.price;
    assign o_best_shares = r_out_best.shares;
    assign o_best_user   = r_out_best.user;
    assign o_entry_count = COUNT_W'(r_out_count);
    assign o_is_empty    = (r_out_count == '0);

endmodule

>>> design/opq_checker.sv
// port-level checks for the order price priority queue, bound to the core module
`timescale 1ns / 1ps

module opq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [opq_pkg::PRICE_W-1:0]  o_best_price,
    input logic [opq_pkg::SHARES_W-1:0] o_best_shares,
    input logic [opq_pkg::USER_W-1:0]   o_best_user,
    input logic [opq_pkg::COUNT_W-1:0]  o_entry_count,
    input logic                         o_is_empty
);
    import opq_pkg::*;

    // result word held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    // accepted word keeps the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again right after accept");

    // new result only after a word was in work
    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without work");

    // empty store reports zero count and zero best order
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> (o_entry_count == '0) && (o_best_price == '0)
            && (o_best_shares == '0) && (o_best_user == '0))
        else $error("empty result carries data");

endmodule

bind order_price_priority_queue_core opq_checker u_opq_checker (.*);
